FILE: rtl/tcw_pkg.sv
// Package of the text console writer: geometry defaults, character codes,
// command and result types shared by the front, queue, back and top level.
// Depends on nothing.
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int QUEUE_DEPTH = 2;

    localparam int CHAR_W     = 8;
    localparam int IDX_W      = 11;
    localparam int COL_PORT_W = 7;
    localparam int ROW_PORT_W = 5;
    localparam int LIN_W      = 11;
    localparam int CELL_W     = 16;

    localparam logic [7:0]  ATTR_RESET = 8'h07;
    localparam logic [15:0] BLANK_CELL = 16'h0700;
    localparam logic [7:0]  CHAR_TAB   = 8'd9;
    localparam logic [7:0]  CHAR_NL    = 8'd10;
    localparam logic [7:0]  CHAR_CR    = 8'd13;
    localparam int          TAB_STEP   = 4;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [2:0] {
        K_PRINT,
        K_NEWLINE,
        K_RETURN,
        K_TAB,
        K_READ,
        K_READ_NONE
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [CHAR_W-1:0] char_code;
        logic [7:0]        attr;
        logic [IDX_W-1:0]  index;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    typedef struct packed {
        logic clearing;
    } t_back_status;

    typedef struct packed {
        logic                  strobe;
        logic [COL_PORT_W-1:0] col;
        logic [ROW_PORT_W-1:0] row;
        logic [LIN_W-1:0]      linear;
        logic [CHAR_W-1:0]     rd_char;
        logic [7:0]            rd_attr;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/tcw_front.sv
// Front end: takes items off the command port and classifies them into
// queue commands. Depends on tcw_pkg.
`default_nettype none

module tcw_front #(
    parameter int CELLS = tcw_pkg::COLUMNS * tcw_pkg::ROWS
) (
    input  wire logic                       i_start,
    input  wire logic                       i_busy,
    input  wire logic                       i_op,
    input  wire logic [tcw_pkg::CHAR_W-1:0] i_char_code,
    input  wire logic [tcw_pkg::IDX_W-1:0]  i_cell_index,
    input  wire logic [7:0]                 i_attr,
    output logic                            o_push,
    output tcw_pkg::t_cmd                   o_cmd
);

    always_comb begin
        o_push          = i_start && !i_busy;
        o_cmd.char_code = i_char_code;
        o_cmd.attr      = i_attr;
        o_cmd.index     = i_cell_index;
        if (i_op == tcw_pkg::OP_READ) begin
            // out-of-range reads answer zero without touching the store
            o_cmd.kind = (32'(i_cell_index) < CELLS) ? tcw_pkg::K_READ
                                                     : tcw_pkg::K_READ_NONE;
        end else begin
            case (i_char_code)
                tcw_pkg::CHAR_NL:  o_cmd.kind = tcw_pkg::K_NEWLINE;
                tcw_pkg::CHAR_CR:  o_cmd.kind = tcw_pkg::K_RETURN;
                tcw_pkg::CHAR_TAB: o_cmd.kind = tcw_pkg::K_TAB;
                default:           o_cmd.kind = tcw_pkg::K_PRINT;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tcw_queue.sv
// Short command queue between front and back end.
// Depends on tcw_pkg.
`default_nettype none

module tcw_queue #(
    parameter int DEPTH = tcw_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  tcw_pkg::t_cmd      i_cmd,
    input  wire logic          i_pop,
    output tcw_pkg::t_cmd      o_cmd,
    output tcw_pkg::t_q_status o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    tcw_pkg::t_cmd r_slot [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [PW:0]   r_count;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        bump = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_cmd           = r_slot[r_rptr];
    assign o_status.empty  = (r_count == '0);
    assign o_status.full   = (r_count == (PW+1)'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= bump(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= bump(r_rptr);
            end
            r_count <= r_count + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tcw_back.sv
// Back end: cursor update, cell store access, scroll and reset clearing.
// Depends on tcw_pkg and tcw_ram.
`default_nettype none

module tcw_back #(
    parameter int COLUMNS = tcw_pkg::COLUMNS,
    parameter int ROWS    = tcw_pkg::ROWS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  tcw_pkg::t_q_status    i_q_status,
    input  tcw_pkg::t_cmd         i_cmd,
    output logic                  o_pop,
    output tcw_pkg::t_back_status o_status,
    output tcw_pkg::t_result      o_result
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = (ROWS > 2) ? $clog2(ROWS) : 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SCROLL,
        S_BLANK
    } t_state;

    t_state    r_state, n_state;
    logic [AW:0]   r_addr, n_addr;
    logic [AW-1:0] r_waddr, n_waddr;
    logic          r_pend, n_pend;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic          r_strobe, n_strobe;
    logic [7:0]    r_rd_char, n_rd_char;
    logic [7:0]    r_rd_attr, n_rd_attr;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [tcw_pkg::CELL_W-1:0] ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [tcw_pkg::CELL_W-1:0] ram_rdata;
    logic [31:0]                lin;

    tcw_ram #(
        .WIDTH(tcw_pkg::CELL_W),
        .DEPTH(CELLS)
    ) u_cells (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        logic [CW:0] col_e;
        logic [RW:0] row_e;
        logic [31:0] pos;

        n_state   = r_state;
        n_addr    = r_addr;
        n_waddr   = r_waddr;
        n_pend    = r_pend;
        n_col     = r_col;
        n_row     = r_row;
        n_strobe  = 1'b0;
        n_rd_char = r_rd_char;
        n_rd_attr = r_rd_attr;
        o_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_addr[AW-1:0];
        ram_wdata = tcw_pkg::BLANK_CELL;
        ram_raddr = '0;
        col_e     = {1'b0, r_col};
        row_e     = {1'b0, r_row};
        pos       = 32'(r_row) * COLUMNS + 32'(r_col);

        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                if (r_addr == (AW+1)'(CELLS - 1)) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + (AW+1)'(1);
                end
            end
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop     = 1'b1;
                    n_rd_char = '0;
                    n_rd_attr = '0;
                    case (i_cmd.kind)
                        tcw_pkg::K_READ: begin
                            ram_raddr = AW'(i_cmd.index);
                            n_state   = S_READ;
                        end
                        tcw_pkg::K_READ_NONE: begin
                            n_strobe = 1'b1;
                        end
                        default: begin
                            case (i_cmd.kind)
                                tcw_pkg::K_NEWLINE: begin
                                    col_e = '0;
                                    row_e = row_e + (RW+1)'(1);
                                end
                                tcw_pkg::K_RETURN: begin
                                    col_e = '0;
                                end
                                tcw_pkg::K_TAB: begin
                                    col_e = (col_e | (CW+1)'(tcw_pkg::TAB_STEP - 1))
                                            + (CW+1)'(1);
                                end
                                default: begin
                                    ram_we    = 1'b1;
                                    ram_waddr = pos[AW-1:0];
                                    ram_wdata = {i_cmd.attr, i_cmd.char_code};
                                    col_e     = col_e + (CW+1)'(1);
                                end
                            endcase
                            if (32'(col_e) >= COLUMNS) begin
                                col_e = '0;
                                row_e = row_e + (RW+1)'(1);
                            end
                            n_col = col_e[CW-1:0];
                            if (row_e == (RW+1)'(ROWS)) begin
                                // cursor fell off the bottom: pin it and scroll
                                n_row   = RW'(ROWS - 1);
                                n_addr  = (AW+1)'(COLUMNS);
                                n_pend  = 1'b0;
                                n_state = S_SCROLL;
                            end else begin
                                n_row    = row_e[RW-1:0];
                                n_strobe = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                n_rd_char = ram_rdata[7:0];
                n_rd_attr = ram_rdata[15:8];
                n_strobe  = 1'b1;
                n_state   = S_IDLE;
            end
            S_SCROLL: begin
                // read one row ahead, write the cell back one row up
                if (r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_waddr;
                    ram_wdata = ram_rdata;
                end
                if (r_addr < (AW+1)'(CELLS)) begin
                    ram_raddr = r_addr[AW-1:0];
                    n_pend    = 1'b1;
                    n_waddr   = AW'(r_addr - (AW+1)'(COLUMNS));
                    n_addr    = r_addr + (AW+1)'(1);
                end else begin
                    n_pend  = 1'b0;
                    n_addr  = (AW+1)'(CELLS - COLUMNS);
                    n_state = S_BLANK;
                end
            end
            S_BLANK: begin
                ram_we = 1'b1;
                if (r_addr == (AW+1)'(CELLS - 1)) begin
                    n_addr   = '0;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_addr = r_addr + (AW+1)'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_waddr   <= n_waddr;
        r_rd_char <= n_rd_char;
        r_rd_attr <= n_rd_attr;
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_addr   <= '0;
            r_pend   <= 1'b0;
            r_col    <= '0;
            r_row    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_pend   <= n_pend;
            r_col    <= n_col;
            r_row    <= n_row;
            r_strobe <= n_strobe;
        end
    end

    assign lin               = 32'(r_row) * COLUMNS + 32'(r_col);
    assign o_status.clearing = (r_state == S_CLEAR);
    assign o_result.strobe   = r_strobe;
    assign o_result.col      = tcw_pkg::COL_PORT_W'(r_col);
    assign o_result.row      = tcw_pkg::ROW_PORT_W'(r_row);
    assign o_result.linear   = lin[tcw_pkg::LIN_W-1:0];
    assign o_result.rd_char  = r_rd_char;
    assign o_result.rd_attr  = r_rd_attr;

endmodule

`default_nettype wire

FILE: rtl/text_console_writer_unit.sv
// Text console writer: an accepted item passes the queue, the back end's S_IDLE
// state and the result register; a cell read adds the store's registered read and
// S_READ, a scroll S_SCROLL and S_BLANK, one cell a cycle through the store's read
// and write ports. Puts are taken one a cycle unless a scroll, cell read or clear holds
// the back end; QUEUE_DEPTH items queue, the receiver never stalls. Busy stays high
// after reset while the store is blanked; configuration writes are taken throughout.
// Depends on tcw_pkg, tcw_front, tcw_queue, tcw_back and tcw_ram.
`default_nettype none

module text_console_writer_unit #(
    parameter int COLUMNS     = tcw_pkg::COLUMNS,
    parameter int ROWS        = tcw_pkg::ROWS,
    parameter int QUEUE_DEPTH = tcw_pkg::QUEUE_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // command port
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           i_op,
    input  wire logic [tcw_pkg::CHAR_W-1:0]     i_char_code,
    input  wire logic [tcw_pkg::IDX_W-1:0]      i_cell_index,
    // result port, one strobe cycle per item
    output logic                                o_result_strobe,
    output logic      [tcw_pkg::COL_PORT_W-1:0] o_cursor_col,
    output logic      [tcw_pkg::ROW_PORT_W-1:0] o_cursor_row,
    output logic      [tcw_pkg::LIN_W-1:0]      o_cursor_linear,
    output logic      [tcw_pkg::CHAR_W-1:0]     o_read_char,
    output logic      [7:0]                     o_read_attr,
    // register port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [2:0]                     paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready
);

    localparam logic REG_TEXT_ATTR = 1'b0;

    logic                  r_text_attr_valid_unused;
    logic [7:0]            r_text_attr, n_text_attr;
    logic                  cfg_write;
    logic                  push;
    logic                  pop;
    tcw_pkg::t_cmd         front_cmd;
    tcw_pkg::t_cmd         queue_cmd;
    tcw_pkg::t_q_status    q_status;
    tcw_pkg::t_back_status back_status;
    tcw_pkg::t_result      result;

    // Register port: pready is tied high, so no access waits; the word index sits
    // in paddr[2], anything past the one register reads as zero and ignores writes.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        n_text_attr = r_text_attr;
        if (cfg_write && (paddr[2] == REG_TEXT_ATTR)) begin
            n_text_attr = pwdata[7:0];
        end
        prdata = (paddr[2] == REG_TEXT_ATTR) ? {24'd0, r_text_attr} : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_attr              <= tcw_pkg::ATTR_RESET;
            r_text_attr_valid_unused <= 1'b0;
        end else begin
            r_text_attr              <= n_text_attr;
            r_text_attr_valid_unused <= 1'b1;
        end
    end

    // Hold off new items while the queue is full, the store is being cleared or in reset.
    assign busy = q_status.full || back_status.clearing || !r_text_attr_valid_unused;

    tcw_front #(
        .CELLS(COLUMNS * ROWS)
    ) u_front (
        .i_start     (start),
        .i_busy      (busy),
        .i_op        (i_op),
        .i_char_code (i_char_code),
        .i_cell_index(i_cell_index),
        .i_attr      (r_text_attr),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    tcw_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_status(q_status)
    );

    tcw_back #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_status(q_status),
        .i_cmd     (queue_cmd),
        .o_pop     (pop),
        .o_status  (back_status),
        .o_result  (result)
    );

    // Drive the result port straight from the back end's registers.
    assign o_result_strobe = result.strobe;
    assign o_cursor_col    = result.col;
    assign o_cursor_row    = result.row;
    assign o_cursor_linear = result.linear;
    assign o_read_char     = result.rd_char;
    assign o_read_attr     = result.rd_attr;

endmodule

`default_nettype wire

FILE: tb/sv/tcw_screen_checker.sv
// Checker of the text console writer: mirrors the cell store, cursor and
// attribute register, predicts each cursor report and compares it on the strobe.
// Depends on tcw_pkg.
module tcw_screen_checker #(
    parameter logic [2:0] ATTR_ADDR = 3'd0
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic                           i_busy,
    input  wire logic                           i_op,
    input  wire logic [tcw_pkg::CHAR_W-1:0]     i_char_code,
    input  wire logic [tcw_pkg::IDX_W-1:0]      i_cell_index,
    input  wire logic                           i_result_strobe,
    input  wire logic [tcw_pkg::COL_PORT_W-1:0] i_cursor_col,
    input  wire logic [tcw_pkg::ROW_PORT_W-1:0] i_cursor_row,
    input  wire logic [tcw_pkg::LIN_W-1:0]      i_cursor_linear,
    input  wire logic [tcw_pkg::CHAR_W-1:0]     i_read_char,
    input  wire logic [7:0]                     i_read_attr,
    input  wire logic                           i_psel,
    input  wire logic                           i_penable,
    input  wire logic                           i_pwrite,
    input  wire logic                           i_pready,
    input  wire logic [2:0]                     i_paddr,
    input  wire logic [31:0]                    i_pwdata,
    input  wire logic [31:0]                    i_prdata,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_result_count,
    output int                                  o_scroll_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int CELL_COUNT = COLUMNS * ROWS;

    typedef struct packed {
        logic [COL_PORT_W-1:0] col;
        logic [ROW_PORT_W-1:0] row;
        logic [LIN_W-1:0]      linear;
        logic [CHAR_W-1:0]     rd_char;
        logic [7:0]            rd_attr;
    } t_cursor_report;

    logic [CELL_W-1:0] screen [CELL_COUNT];
    int                col_now;
    int                row_now;
    logic [7:0]        text_attr;
    t_cursor_report    reports_due [$];
    t_cursor_report    oldest;
    int                mismatches;
    int                results_seen;
    int                scrolls_done;

    function automatic void scroll_up(int rows_gone);
        int shift;
        shift = rows_gone * COLUMNS;
        for (int i = 0; i < CELL_COUNT; i++) begin
            if (i + shift < CELL_COUNT) begin
                screen[i] = screen[i + shift];
            end else begin
                screen[i] = BLANK_CELL;
            end
        end
    endfunction

    // Apply one item to the mirrored console and return the report it causes.
    function automatic t_cursor_report console_step(logic op, logic [CHAR_W-1:0] ch,
                                                    logic [IDX_W-1:0] idx);
        t_cursor_report rep;
        int             pos;
        rep = '0;
        if (op == OP_PUT) begin
            case (ch)
                CHAR_NL: begin
                    col_now = 0;
                    row_now++;
                end
                CHAR_TAB: begin
                    col_now = col_now + TAB_STEP - (col_now % TAB_STEP);
                    if (col_now >= COLUMNS) begin
                        col_now = 0;
                        row_now++;
                    end
                end
                CHAR_CR: begin
                    col_now = 0;
                end
                default: begin
                    pos = row_now * COLUMNS + col_now;
                    if (pos < CELL_COUNT) screen[pos] = {text_attr, ch};
                    col_now++;
                    if (col_now >= COLUMNS) begin
                        col_now = 0;
                        row_now++;
                    end
                end
            endcase
            if (row_now > ROWS - 1) begin
                scroll_up(row_now - (ROWS - 1));
                row_now = ROWS - 1;
                scrolls_done++;
            end
        end else if (int'(idx) < CELL_COUNT) begin
            rep.rd_char = screen[idx][7:0];
            rep.rd_attr = screen[idx][15:8];
        end
        rep.col    = COL_PORT_W'(col_now);
        rep.row    = ROW_PORT_W'(row_now);
        rep.linear = LIN_W'(row_now * COLUMNS + col_now);
        return rep;
    endfunction

    task automatic flag(string what, int unsigned want, int unsigned got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    task automatic check_field(string what, int unsigned want, int unsigned got);
        if (want != got) flag(what, want, got);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CELL_COUNT; i++) screen[i] = BLANK_CELL;
            col_now      = 0;
            row_now      = 0;
            text_attr    = ATTR_RESET;
            mismatches   = 0;
            results_seen = 0;
            scrolls_done = 0;
            reports_due.delete();
        end else begin
            // Retire the result before taking a new item so that it meets the older one.
            if (i_result_strobe) begin
                results_seen++;
                if (reports_due.size() == 0) begin
                    flag("result with no item waiting", 0, 1);
                end else begin
                    oldest = reports_due.pop_front();
                    check_field("cursor_col", oldest.col, i_cursor_col);
                    check_field("cursor_row", oldest.row, i_cursor_row);
                    check_field("cursor_linear", oldest.linear, i_cursor_linear);
                    check_field("read_char", oldest.rd_char, i_read_char);
                    check_field("read_attr", oldest.rd_attr, i_read_attr);
                end
            end
            if (i_start && !i_busy) begin
                reports_due.push_back(console_step(i_op, i_char_code, i_cell_index));
            end
            if (i_psel && i_penable && i_pready && i_paddr == ATTR_ADDR) begin
                if (i_pwrite) begin
                    text_attr = i_pwdata[7:0];
                end else begin
                    check_field("text_attr read back", text_attr, i_prdata[7:0]);
                end
            end
        end
        o_fail_count   <= mismatches;
        o_pending      <= reports_due.size();
        o_result_count <= results_seen;
        o_scroll_count <= scrolls_done;
    end

endmodule

FILE: tb/sv/tb_text_console_writer_unit.sv
// Testbench top of the text console writer: drives put and read items and
// attribute writes; the verdict rests on the checker's fail and pending counts.
// Depends on tcw_pkg, text_console_writer_unit and tcw_screen_checker.
module tb_text_console_writer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam logic [2:0] ATTR_ADDR    = 3'd0;
    localparam int         CELL_COUNT   = COLUMNS * ROWS;
    // A scroll walks the whole store, so one item may hold everything off while
    // it runs, and the queue can stack two of them.
    localparam int         STALL_LIMIT  = 10 * CELL_COUNT;
    localparam int         DRAIN_CYCLES = CELL_COUNT + 16;
    localparam int         PHASES       = 6;
    localparam int         PHASE_ITEMS  = 175;
    localparam int         STEADY_PHASE = 3;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  start           = 1'b0;
    logic                  busy;
    logic                  i_op            = OP_PUT;
    logic [CHAR_W-1:0]     i_char_code     = '0;
    logic [IDX_W-1:0]      i_cell_index    = '0;
    logic                  o_result_strobe;
    logic [COL_PORT_W-1:0] o_cursor_col;
    logic [ROW_PORT_W-1:0] o_cursor_row;
    logic [LIN_W-1:0]      o_cursor_linear;
    logic [CHAR_W-1:0]     o_read_char;
    logic [7:0]            o_read_attr;
    logic                  psel            = 1'b0;
    logic                  penable         = 1'b0;
    logic                  pwrite          = 1'b0;
    logic [2:0]            paddr           = '0;
    logic [31:0]           pwdata          = '0;
    logic [31:0]           prdata;
    logic                  pready;

    int fail_count;
    int pending_reports;
    int results_checked;
    int scrolls_seen;

    int  items_sent;
    int  puts_sent;
    int  reads_sent;
    int  far_reads_sent;
    int  attr_settings;
    int  stall_cycles = 0;
    // Set to hold start high back to back with no idle gaps.
    bit  steady;

    always #5 i_clk = ~i_clk;

    text_console_writer_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_char_code     (i_char_code),
        .i_cell_index    (i_cell_index),
        .o_result_strobe (o_result_strobe),
        .o_cursor_col    (o_cursor_col),
        .o_cursor_row    (o_cursor_row),
        .o_cursor_linear (o_cursor_linear),
        .o_read_char     (o_read_char),
        .o_read_attr     (o_read_attr),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    tcw_screen_checker #(
        .ATTR_ADDR (ATTR_ADDR)
    ) u_screen_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_op            (i_op),
        .i_char_code     (i_char_code),
        .i_cell_index    (i_cell_index),
        .i_result_strobe (o_result_strobe),
        .i_cursor_col    (o_cursor_col),
        .i_cursor_row    (o_cursor_row),
        .i_cursor_linear (o_cursor_linear),
        .i_read_char     (o_read_char),
        .i_read_attr     (o_read_attr),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_prdata        (prdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending_reports),
        .o_result_count  (results_checked),
        .o_scroll_count  (scrolls_seen)
    );

    // Watchdog: count cycles with no item, no result and no register access;
    // the clearing sweep after reset and every scroll stay well under the limit.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_strobe || (psel && penable && pready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("no progress for %0d cycles", stall_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // One register access: setup cycle, then hold the access cycle until pready.
    // Drop psel afterward and leave the bus idle so the next access starts clean.
    task automatic reg_access(logic write, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= ATTR_ADDR;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write the print attribute and read it back so the checker sees both ways.
    task automatic set_attr(logic [7:0] value);
        reg_access(1'b1, {24'h0, value});
        reg_access(1'b0, 32'h0);
        attr_settings++;
    endtask

    // Offer one item and hold it until the block takes it. An optional idle gap
    // goes in front, so gaps land on any phase of the work.
    task automatic send_item(logic op, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
        if (!steady && $urandom_range(99) < 21) begin
            start <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_op         <= op;
        i_char_code  <= ch;
        i_cell_index <= idx;
        do @(posedge i_clk); while (busy);
        items_sent++;
        if (op == OP_PUT) begin
            puts_sent++;
        end else begin
            reads_sent++;
            if (int'(idx) >= CELL_COUNT) far_reads_sent++;
        end
    endtask

    // Fill the field that the operation ignores with noise.
    task automatic send_put(logic [CHAR_W-1:0] ch);
        send_item(OP_PUT, ch, IDX_W'($urandom_range(2047)));
    endtask

    task automatic send_read(logic [IDX_W-1:0] idx);
        send_item(OP_READ, CHAR_W'($urandom_range(255)), idx);
    endtask

    // Drop start and wait until every cursor report has come back.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_reports != 0) @(posedge i_clk);
    endtask

    // Random traffic in bursts: lines of text, runs of newlines that push the
    // screen into scrolling, reads anywhere in the store, in its last two rows or
    // past its end, and plain noise over every field.
    task automatic run_random_phase(int quota);
        int goal;
        int kind;
        int len;
        int r;
        goal = items_sent + quota;
        while (items_sent < goal) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
                len = $urandom_range(90, 1);
                repeat (len) begin
                    r = $urandom_range(99);
                    if (r < 6) begin
                        send_put(CHAR_TAB);
                    end else if (r < 9) begin
                        send_put(CHAR_CR);
                    end else begin
                        send_put(CHAR_W'($urandom_range(255)));
                    end
                end
                if ($urandom_range(9) < 7) send_put(CHAR_NL);
            end else if (kind < 55) begin
                repeat ($urandom_range(30, 1)) send_put(CHAR_NL);
            end else if (kind < 80) begin
                repeat ($urandom_range(10, 1)) begin
                    r = $urandom_range(99);
                    if (r < 10) begin
                        send_read(IDX_W'($urandom_range(2047, CELL_COUNT)));
                    end else if (r < 35) begin
                        send_read(IDX_W'($urandom_range(CELL_COUNT - 1,
                                                        CELL_COUNT - 2 * COLUMNS)));
                    end else begin
                        send_read(IDX_W'($urandom_range(CELL_COUNT - 1)));
                    end
                end
            end else begin
                repeat ($urandom_range(10, 1)) begin
                    send_item(logic'($urandom_range(1)), CHAR_W'($urandom_range(255)),
                              IDX_W'($urandom_range(2047)));
                end
            end
        end
    endtask

    initial begin
        logic [7:0] phase_attr [PHASES];
        phase_attr = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h3C, 8'h07};
        items_sent     = 0;
        puts_sent      = 0;
        reads_sent     = 0;
        far_reads_sent = 0;
        attr_settings  = 0;
        steady         = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // The block takes register writes during its clearing sweep.
        set_attr(8'h1F);

        // Directed: both ends of the character byte, reads of a printed cell,
        // the last cell and cells past the store, return, tabs up to column 76,
        // a tab from column 77 that wraps, and a newline.
        send_put(8'h41);
        send_put(8'h00);
        send_put(8'hFF);
        send_read(IDX_W'(2));
        send_read(IDX_W'(CELL_COUNT - 1));
        send_read(IDX_W'(CELL_COUNT));
        send_read(IDX_W'(2047));
        send_put(CHAR_CR);
        repeat (19) send_put(CHAR_TAB);
        send_put(8'h5A);
        send_put(CHAR_TAB);
        send_put(CHAR_NL);
        send_read(IDX_W'(0));
        drain();

        // Random phases, each under its own attribute; one runs without gaps.
        for (int phase = 0; phase < PHASES; phase++) begin
            set_attr(phase == 2 ? 8'($urandom_range(255)) : phase_attr[phase]);
            steady = (phase == STEADY_PHASE);
            run_random_phase(PHASE_ITEMS);
            drain();
        end

        // Let a late scroll or a stray strobe show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d puts and %0d cell reads (%0d past the last cell) under %0d attributes",
                 puts_sent, reads_sent, far_reads_sent, attr_settings);
        $display("checked %0d cursor reports across %0d screen scrolls",
                 results_checked, scrolls_seen);
        if (fail_count == 0 && pending_reports == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: text_console_writer_unit.f
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_front.sv
rtl/tcw_queue.sv
rtl/tcw_back.sv
rtl/text_console_writer_unit.sv
tb/sv/tcw_screen_checker.sv
tb/sv/tb_text_console_writer_unit.sv
